// ===== sv/tpc_pkg.sv =====
// Package for the triggered peak capture block: widths, register indexes,
// reset values and the word types of the sample and result channels.
// Depends on nothing; every other file of the block imports it.
package tpc_pkg;

    localparam int STORE_DEPTH_DEF = 128;

    localparam int SAMPLE_W     = 10;
    localparam int TIME_W       = 32;
    localparam int MS_W         = 16;
    localparam int TARGET_W     = 8;
    localparam int CFG_INDEX_W  = 4;
    localparam int CFG_DATA_W   = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_TRIGGER_THRESHOLD = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PEAK_WINDOW_MS    = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_COOLDOWN_MS       = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_TARGET_COUNT      = 4'd3;

    localparam logic [SAMPLE_W-1:0] THRESHOLD_RST = 10'd527;
    localparam logic [MS_W-1:0]     WINDOW_RST    = 16'd50;
    localparam logic [MS_W-1:0]     COOLDOWN_RST  = 16'd3000;
    localparam logic [TARGET_W-1:0] TARGET_RST    = 8'd100;

    localparam logic KIND_LIVE     = 1'b0;
    localparam logic KIND_READBACK = 1'b1;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic [TIME_W-1:0]   now_ms;
    } sample_word_t;

    typedef struct packed {
        logic                kind;
        logic [SAMPLE_W-1:0] peak_value;
        logic                last;
    } result_word_t;

endpackage

// ===== sv/tpc_out_skid.sv =====
// Two-entry output buffer for result words: an output register and a skid
// register, so that the upstream stall is a registered signal.
// Depends on tpc_pkg for the result word type.
module tpc_out_skid
    import tpc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  result_word_t push_word,
    output logic         full,
    output logic         res_valid,
    input  logic         res_stall,
    output result_word_t res_word
);

    logic         main_valid_reg;
    logic         skid_valid_reg;
    result_word_t main_reg;
    result_word_t skid_reg;
    logic         pop;

    assign pop       = main_valid_reg && !res_stall;
    assign full      = skid_valid_reg;
    assign res_valid = main_valid_reg;
    assign res_word  = main_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            // No push can arrive while the skid register is occupied.
            if (pop)
            begin
                main_reg       <= skid_reg;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg || pop)
            begin
                main_reg       <= push_word;
                main_valid_reg <= 1'b1;
            end
            else
            begin
                skid_reg       <= push_word;
                skid_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            main_valid_reg <= 1'b0;
        end
    end

endmodule

// ===== sv/triggered_peak_capture.sv =====
// Triggered peak capture: an accepted sample word's result word is registered in
// the output buffer. While smp_stall is low, one sample word is taken every cycle;
// the peak store is read one word ahead, so readback also runs at one per cycle.
// Reset (rst_n, asynchronous, active low) restores the register defaults, the
// waiting phase and empty counters; the peak store itself is not cleared.
module triggered_peak_capture
    import tpc_pkg::*;
#(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   smp_valid,
    output logic                   smp_stall,
    input  sample_word_t           smp_word,
    output logic                   res_valid,
    input  logic                   res_stall,
    output result_word_t           res_word,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int CNT_W = $clog2(STORE_DEPTH + 1);
    localparam int AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CMP_W = (CNT_W > TARGET_W) ? CNT_W : TARGET_W;

    typedef enum logic [2:0] {
        PH_WAIT,
        PH_REC,
        PH_COOL,
        PH_READ,
        PH_DONE
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [TIME_W-1:0]   start_reg, start_next;
    logic [SAMPLE_W-1:0] peak_reg, peak_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    ridx_reg, ridx_next;

    logic [SAMPLE_W-1:0] threshold_reg;
    logic [MS_W-1:0]     window_reg;
    logic [MS_W-1:0]     cooldown_reg;
    logic [TARGET_W-1:0] target_reg;

    logic [SAMPLE_W-1:0] store_mem [STORE_DEPTH];
    logic [SAMPLE_W-1:0] rd_data_reg;
    logic [AW-1:0]       rd_addr;
    logic                mem_we;
    logic [AW-1:0]       mem_wa;
    logic [SAMPLE_W-1:0] mem_wd;

    logic                accept;
    logic                push;
    result_word_t        push_word;
    logic                buf_full;
    logic [CNT_W-1:0]    eff_target;
    logic [TIME_W-1:0]   elapsed;

    assign cfg_ready = 1'b1;
    assign smp_stall = buf_full;
    assign accept    = smp_valid && !buf_full;
    assign elapsed   = smp_word.now_ms - start_reg;

    // A target of zero acts as one, and anything above the store depth is clipped.
    always_comb
    begin
        if (target_reg == '0)
            eff_target = CNT_W'(1);
        else if (CMP_W'(target_reg) > CMP_W'(STORE_DEPTH))
            eff_target = CNT_W'(STORE_DEPTH);
        else
            eff_target = CNT_W'(target_reg);
    end

    always_comb
    begin
        phase_t           ph;
        logic [CNT_W-1:0] sc;
        logic [CNT_W-1:0] ri;
        logic [CNT_W-1:0] ri_inc;

        ph         = phase_reg;
        sc         = count_reg;
        ri         = ridx_reg;
        ri_inc     = ri + CNT_W'(1);
        phase_next = phase_reg;
        start_next = start_reg;
        peak_next  = peak_reg;
        count_next = count_reg;
        ridx_next  = ridx_reg;
        push       = 1'b0;
        push_word  = '0;
        mem_we     = 1'b0;
        mem_wa     = count_reg[AW-1:0];
        mem_wd     = peak_reg;

        if (accept)
        begin
            // The collection check comes before the sample is looked at.
            if ((ph inside {PH_WAIT, PH_REC, PH_COOL}) && sc >= eff_target)
            begin
                sc = eff_target;
                ri = '0;
                ri_inc = CNT_W'(1);
                ph = PH_READ;
            end
            phase_next = ph;
            count_next = sc;
            ridx_next  = ri;

            case (ph)
                PH_WAIT:
                begin
                    if (smp_word.sample >= threshold_reg)
                    begin
                        peak_next  = smp_word.sample;
                        start_next = smp_word.now_ms;
                        phase_next = PH_REC;
                    end
                end
                PH_REC:
                begin
                    if (elapsed < TIME_W'(window_reg))
                    begin
                        if (smp_word.sample > peak_reg)
                            peak_next = smp_word.sample;
                    end
                    else
                    begin
                        mem_we               = (CMP_W'(sc) < CMP_W'(STORE_DEPTH));
                        mem_wa               = sc[AW-1:0];
                        count_next           = sc + CNT_W'(1);
                        start_next           = smp_word.now_ms;
                        phase_next           = PH_COOL;
                        push                 = 1'b1;
                        push_word.kind       = KIND_LIVE;
                        push_word.peak_value = peak_reg;
                        push_word.last       = 1'b0;
                    end
                end
                PH_COOL:
                begin
                    if (elapsed >= TIME_W'(cooldown_reg))
                    begin
                        phase_next = PH_WAIT;
                        peak_next  = '0;
                    end
                end
                PH_READ:
                begin
                    if (ri < sc)
                    begin
                        push                 = 1'b1;
                        push_word.kind       = KIND_READBACK;
                        push_word.peak_value = rd_data_reg;
                        push_word.last       = (ri_inc == sc);
                        ridx_next            = ri_inc;
                        if (ri_inc >= sc)
                            phase_next = PH_DONE;
                    end
                    else
                    begin
                        phase_next = PH_DONE;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // The store is read at the index the next readback word will use.
    assign rd_addr = ridx_next[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
            store_mem[mem_wa] <= mem_wd;
        if (mem_we && mem_wa == rd_addr)
            rd_data_reg <= mem_wd;
        else
            rd_data_reg <= store_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_WAIT;
            start_reg     <= '0;
            peak_reg      <= '0;
            count_reg     <= '0;
            ridx_reg      <= '0;
            threshold_reg <= THRESHOLD_RST;
            window_reg    <= WINDOW_RST;
            cooldown_reg  <= COOLDOWN_RST;
            target_reg    <= TARGET_RST;
        end
        else
        begin
            phase_reg <= phase_next;
            start_reg <= start_next;
            peak_reg  <= peak_next;
            count_reg <= count_next;
            ridx_reg  <= ridx_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_TRIGGER_THRESHOLD: threshold_reg <= cfg_data[SAMPLE_W-1:0];
                    REG_PEAK_WINDOW_MS:    window_reg    <= cfg_data[MS_W-1:0];
                    REG_COOLDOWN_MS:       cooldown_reg  <= cfg_data[MS_W-1:0];
                    REG_TARGET_COUNT:      target_reg    <= cfg_data[TARGET_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    tpc_out_skid u_out_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .full      (buf_full),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_word  (res_word)
    );

endmodule
